// ----- rtl/gcw_pkg.sv -----
// Shared types, constants and the luma function of the grey 3x3 window filter.
// Depends on nothing; gcw_cell and the top level import it.
package gcw_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int IMG_W_W   = 11;
  localparam int CMP_W     = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
  localparam int MIN_WIDTH = 3;

  // Pixel, grey and weight widths
  localparam int PIX_W  = 8;
  localparam int GREY_W = 8;
  localparam int WGT_W  = 8;
  localparam int PROD_W = WGT_W + GREY_W + 1;
  localparam int ROWS   = 3;
  localparam int COLS   = 3;
  localparam int RES_W  = 20;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  // Q0.16 luma coefficients
  localparam int FRAC    = 16;
  localparam int LUMA_R  = 19595;
  localparam int LUMA_G  = 38470;
  localparam int LUMA_B  = 7471;
  localparam int LPROD_W = PIX_W + FRAC;

  typedef logic [GREY_W-1:0]       grey_t;
  typedef grey_t [ROWS-1:0]        grey_col_t;
  typedef logic signed [RES_W-1:0] sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_WEIGHTS_COL0,
    REG_WEIGHTS_COL1,
    REG_WEIGHTS_COL2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ACC0,
    ST_ACC1,
    ST_ACC2,
    ST_DONE
  } state_t;

  // Sum of three separately truncated channel products
  function automatic grey_t to_grey(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b);
    logic [LPROD_W-1:0] pr;
    logic [LPROD_W-1:0] pg;
    logic [LPROD_W-1:0] pb;
    pr = LPROD_W'(r) * LPROD_W'(LUMA_R);
    pg = LPROD_W'(g) * LPROD_W'(LUMA_G);
    pb = LPROD_W'(b) * LPROD_W'(LUMA_B);
    return GREY_W'((pr >> FRAC) + (pg >> FRAC) + (pb >> FRAC));
  endfunction

endpackage

// ----- rtl/gcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gcw_cell.sv -----
// One column cell of the window chain: holds three grey values, adds its weighted
// column to the running sum from its neighbour. Depends on gcw_pkg.
module gcw_cell (
  input  logic                     clk,
  input  logic                     shift,
  input  gcw_pkg::grey_col_t       col_in,
  input  logic [gcw_pkg::CFG_W-1:0] weights,
  input  gcw_pkg::sum_t            acc_in,
  output gcw_pkg::grey_col_t       col_out,
  output gcw_pkg::sum_t            acc_out
);
  import gcw_pkg::*;

  logic signed [PROD_W-1:0] prod [ROWS];
  sum_t                     dot;

  // Weighted column: signed weight times unsigned grey per row offset
  always_comb begin
    dot = '0;
    for (int y = 0; y < ROWS; y++) begin
      prod[y] = $signed(weights[y*WGT_W +: WGT_W]) * $signed({1'b0, col_out[y]});
      dot     = dot + sum_t'(prod[y]);
    end
  end

  // Take the neighbour's column on a shift; pass the running sum on every cycle
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
    acc_out <= acc_in + dot;
  end

endmodule

// ----- rtl/grey_conv3x3_window.sv -----
// Top level of the grey 3x3 window filter: position tracking, line stores,
// chain of three column cells and the output register.
// Depends on gcw_pkg, gcw_ram and gcw_cell.
//
// Usage:
//   Pixels enter on the in channel (red, green, blue, start_of_frame,
//   end_of_frame) in raster order. Each is turned into luma and pushed into a
//   3x3 window fed by two line stores. Once the pixel sits at row 2 or later and
//   column 2 or later, one beat leaves on the out channel: filtered_value, the
//   signed weighted window sum, and last_of_frame.
//   The cfg channel writes image_width (index 0) and the three weight columns
//   (indices 1 to 3); cfg_ready is always high. Write only while idle.
//   Timing: each pixel passes through the sequencer states in order: accept,
//   line store read and window shift, then ACC0 to ACC2 while the running sum
//   passes along the cell chain, then the hand-over to the output register.
//   The next pixel is taken in the cycle after, once the last one is through.
//   A result waiting in the output register does not block the next pixel; a
//   stalled receiver only holds the block once a second result is ready.
//   Reset clears position, weights and control; line stores start unwritten.
module grey_conv3x3_window (
  input  logic                          clk,
  input  logic                          rst,
  // Pixel channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gcw_pkg::PIX_W-1:0]     red,
  input  logic [gcw_pkg::PIX_W-1:0]     green,
  input  logic [gcw_pkg::PIX_W-1:0]     blue,
  input  logic                          start_of_frame,
  input  logic                          end_of_frame,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [gcw_pkg::RES_W-1:0] filtered_value,
  output logic                          last_of_frame,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcw_pkg::CFG_W-1:0]     cfg_data
);
  import gcw_pkg::*;

  state_t state, state_next;

  logic [IMG_W_W-1:0] image_width;
  logic [CFG_W-1:0]   weights [COLS];

  logic [COL_W-1:0] col;
  logic [1:0]       row;      // saturates at 2: only "row at least 2" matters
  grey_t            grey;
  logic             eof;
  logic             produce;

  logic             in_acc;
  logic             shift;
  logic             load_out;
  logic             out_free;
  logic [COL_W-1:0] col_eff;
  logic [CMP_W-1:0] width_force;
  logic [CMP_W-1:0] col_inc;

  grey_t     upper_rd, middle_rd;
  grey_col_t new_col;
  grey_col_t cols [COLS];
  sum_t      accs [COLS];

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;
  assign col_eff   = start_of_frame ? '0 : col;

  // Clamp the programmed width into the supported range
  always_comb begin
    if (CMP_W'(image_width) < CMP_W'(MIN_WIDTH)) begin
      width_force = CMP_W'(MIN_WIDTH);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      width_force = CMP_W'(MAX_WIDTH);
    end else begin
      width_force = CMP_W'(image_width);
    end
  end

  assign col_inc = CMP_W'(col) + CMP_W'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMG_W_W'(MAX_WIDTH);
      for (int x = 0; x < COLS; x++) begin
        weights[x] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width <= cfg_data[IMG_W_W-1:0];
        REG_WEIGHTS_COL0: weights[0]  <= cfg_data;
        REG_WEIGHTS_COL1: weights[1]  <= cfg_data;
        REG_WEIGHTS_COL2: weights[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_ACC0;
      ST_ACC0:  state_next = ST_ACC1;
      ST_ACC1:  state_next = ST_ACC2;
      ST_ACC2:  state_next = ST_DONE;
      ST_DONE:  if (!produce || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SHIFT: shift    = 1'b1;
      ST_DONE:  load_out = produce & out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the pixel and apply the frame start; advance position after the shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      produce <= 1'b0;
    end else if (in_acc) begin
      col <= col_eff;
      if (start_of_frame) begin
        row <= '0;
      end
    end else if (shift) begin
      produce <= (row == 2'd2) && (col >= COL_W'(2));
      if (eof) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= width_force) begin
        col <= '0;
        if (row != 2'd2) begin
          row <= row + 2'd1;
        end
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      grey <= to_grey(red, green, blue);
      eof  <= end_of_frame;
    end
  end

  // Line stores: read at the accept edge, write back during the shift
  gcw_ram #(.WIDTH(GREY_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (shift),
    .waddr (col),
    .wdata (middle_rd),
    .re    (in_acc),
    .raddr (col_eff),
    .rdata (upper_rd)
  );

  gcw_ram #(.WIDTH(GREY_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (shift),
    .waddr (col),
    .wdata (grey),
    .re    (in_acc),
    .raddr (col_eff),
    .rdata (middle_rd)
  );

  // Newest column: oldest row first
  assign new_col[0] = upper_rd;
  assign new_col[1] = middle_rd;
  assign new_col[2] = grey;

  // Cell chain: columns move towards cell 0, the sum moves towards cell 2
  for (genvar x = 0; x < COLS; x++) begin : g_cell
    gcw_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  ((x == COLS - 1) ? new_col : cols[(x + 1) % COLS]),
      .weights (weights[x]),
      .acc_in  ((x == 0) ? sum_t'(0) : accs[(x + COLS - 1) % COLS]),
      .col_out (cols[x]),
      .acc_out (accs[x])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_value <= accs[COLS-1];
      last_of_frame  <= eof;
    end
  end

endmodule
